/* design/c6502eu_pkg.sv */
// Package for the 6502 execute unit: operation codes, item and result types.
// No dependencies; the front end, back end, top level and simulation files import it.
package c6502eu_pkg;

    // Operation classes in dispatch order; 56 to 63 behave as NOP.
    typedef enum logic [5:0] {
        K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_TAX, K_TAY,
        K_TSX, K_TXA, K_TXS, K_TYA, K_PHA, K_PHP, K_PLA, K_PLP,
        K_ASL, K_LSR, K_ROL, K_ROR, K_AND, K_BIT, K_EOR, K_ORA,
        K_ADC, K_CMP, K_CPX, K_CPY, K_SBC, K_DEC, K_DEX, K_DEY,
        K_INC, K_INX, K_INY, K_BRK, K_JMP, K_JSR, K_RTI, K_RTS,
        K_BCC, K_BCS, K_BEQ, K_BMI, K_BNE, K_BPL, K_BVC, K_BVS,
        K_CLC, K_CLD, K_CLI, K_CLV, K_SEC, K_SED, K_SEI, K_NOP
    } t_kind;

    // States of the back-end sequencer.
    typedef enum logic [2:0] {S_IDLE, S_READ, S_CAP, S_EXEC, S_EMIT} t_state;

    // Status register bit positions.
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] RESET_SP   = 8'hFD;
    localparam logic [7:0] RESET_P    = 8'h24;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Classified word held in the queue between the front and the back.
    typedef struct packed {
        logic [5:0]  kind;
        logic        accumulator_mode;
        logic [7:0]  operand;
        logic [15:0] address;
        logic [1:0]  instr_length;
        logic [1:0]  pulls;
    } t_item;

    // One result word.
    typedef struct packed {
        logic        mem_write;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] next_pc;
        logic [7:0]  reg_a;
        logic [7:0]  reg_x;
        logic [7:0]  reg_y;
        logic [7:0]  stack_pointer;
        logic [7:0]  flags;
        logic        last;
    } t_res;

    // Number of stack bytes an operation class pulls.
    function automatic logic [1:0] pull_count(input logic [5:0] kind);
        logic [1:0] n;
        n = 2'd0;
        case (t_kind'(kind))
            K_PLA, K_PLP: n = 2'd1;
            K_RTS:        n = 2'd2;
            K_RTI:        n = 2'd3;
            default:      n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

/* design/c6502eu_if.sv */
// Channel interfaces for instruction words and result words.
// Depends on nothing but the valid/ready handshake convention.
interface c6502eu_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic        accumulator_mode;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [1:0]  instr_length;

    modport source (output valid, kind, accumulator_mode, operand, address, instr_length,
                    input ready);
    modport sink   (input valid, kind, accumulator_mode, operand, address, instr_length,
                    output ready);
endinterface

interface c6502eu_out_if;
    logic        valid;
    logic        ready;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [7:0]  reg_a;
    logic [7:0]  reg_x;
    logic [7:0]  reg_y;
    logic [7:0]  stack_pointer;
    logic [7:0]  flags;
    logic        last;

    modport source (output valid, mem_write, write_address, write_data, next_pc, reg_a,
                    reg_x, reg_y, stack_pointer, flags, last, input ready);
    modport sink   (input valid, mem_write, write_address, write_data, next_pc, reg_a,
                    reg_x, reg_y, stack_pointer, flags, last, output ready);
endinterface

/* design/c6502eu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module c6502eu_ram #(
    parameter int unsigned P_WIDTH = 8,
    parameter int unsigned P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/c6502eu_front.sv */
// Front end: accepts instruction words, classifies them and queues them.
// Depends on c6502eu_pkg and c6502eu_in_if.
module c6502eu_front
    import c6502eu_pkg::*;
#(
    parameter int unsigned P_QDEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    c6502eu_in_if.sink    i_in,
    output logic          o_q_valid,
    output t_item         o_q_item,
    input  logic          i_q_pop
);
    localparam int unsigned PW = $clog2(P_QDEPTH);
    localparam int unsigned CW = $clog2(P_QDEPTH + 1);

    t_item          r_q [P_QDEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           push, pop;
    t_item          item;

    // Classify the incoming word.
    always_comb begin
        item.kind             = i_in.kind;
        item.accumulator_mode = i_in.accumulator_mode;
        item.operand          = i_in.operand;
        item.address          = i_in.address;
        item.instr_length     = i_in.instr_length;
        item.pulls            = pull_count(i_in.kind);
    end

    assign i_in.ready = (r_cnt != CW'(P_QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_q[r_rp];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(P_QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(P_QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end
endmodule

/* design/c6502eu_back.sv */
// Back end: register file, stack page RAM, execution and result sequencing.
// Depends on c6502eu_pkg, c6502eu_out_if and c6502eu_ram.
module c6502eu_back
    import c6502eu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_item         i_q_item,
    output logic          o_q_pop,
    c6502eu_out_if.source o_res
);
    t_state       r_state, n_state;
    t_item        r_item;
    logic [1:0]   r_cnt, n_cnt;
    logic [7:0]   r_b [3];
    logic [7:0]   r_a, r_x, r_y, r_sp, r_p;
    logic [15:0]  r_pc;
    logic [15:0]  r_wa [3];
    logic [7:0]   r_wd [3];
    logic [1:0]   r_nw, r_k;
    logic         r_ov;
    t_res         r_out;

    logic [7:0]   rd_data, ram_raddr;
    logic         ram_we, load;
    logic [7:0]   e_a, e_x, e_y, e_sp, e_p;
    logic [15:0]  e_pc;
    logic [15:0]  e_wa [3];
    logic [7:0]   e_wd [3];
    logic [1:0]   e_nw;

    c6502eu_ram #(.P_WIDTH(8), .P_DEPTH(256)) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wa[r_k][7:0]),
        .i_wdata (r_wd[r_k]),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign ram_raddr = r_sp + {6'd0, r_cnt} + 8'd1;
    assign load      = (r_state == S_EMIT) && (!r_ov || o_res.ready);
    assign ram_we    = load && (r_k < r_nw) && (r_wa[r_k][15:8] == STACK_PAGE);

    // Execute one instruction from the queued word and the pulled bytes.
    always_comb begin
        logic [7:0]  m, v, r, mm;
        logic [8:0]  sum;
        logic [15:0] ret, nxt;
        logic        taken;
        m     = r_item.operand;
        e_a   = r_a;  e_x = r_x;  e_y = r_y;  e_sp = r_sp;  e_p = r_p;
        e_nw  = 2'd0;
        for (int i = 0; i < 3; i++) begin
            e_wa[i] = '0;
            e_wd[i] = '0;
        end
        ret   = r_pc + 16'd2;
        nxt   = r_pc + {14'd0, r_item.instr_length};
        taken = 1'b0;
        v     = r_item.accumulator_mode ? r_a : m;
        r     = '0;
        mm    = '0;
        sum   = '0;
        case (t_kind'(r_item.kind))
            K_LDA: e_a = m;
            K_LDX: e_x = m;
            K_LDY: e_y = m;
            K_STA: begin e_wa[0] = r_item.address; e_wd[0] = r_a; e_nw = 2'd1; end
            K_STX: begin e_wa[0] = r_item.address; e_wd[0] = r_x; e_nw = 2'd1; end
            K_STY: begin e_wa[0] = r_item.address; e_wd[0] = r_y; e_nw = 2'd1; end
            K_TAX: e_x = r_a;
            K_TAY: e_y = r_a;
            K_TSX: e_x = r_sp;
            K_TXA: e_a = r_x;
            K_TXS: e_sp = r_x;
            K_TYA: e_a = r_y;
            K_PHA, K_PHP: begin
                e_wa[0] = {STACK_PAGE, r_sp};
                e_wd[0] = (r_item.kind == K_PHA) ? r_a : (r_p | 8'h30);
                e_nw    = 2'd1;
                e_sp    = r_sp - 8'd1;
            end
            K_PLA: begin e_a = r_b[0]; e_sp = r_sp + 8'd1; end
            K_PLP: begin e_p = (r_b[0] & 8'hEF) | 8'h20; e_sp = r_sp + 8'd1; end
            K_ASL, K_LSR, K_ROL, K_ROR: begin
                case (t_kind'(r_item.kind))
                    K_ASL:   begin e_p[FLAG_C] = v[7]; r = {v[6:0], 1'b0}; end
                    K_LSR:   begin e_p[FLAG_C] = v[0]; r = {1'b0, v[7:1]}; end
                    K_ROL:   begin e_p[FLAG_C] = v[7]; r = {v[6:0], r_p[FLAG_C]}; end
                    default: begin e_p[FLAG_C] = v[0]; r = {r_p[FLAG_C], v[7:1]}; end
                endcase
                if (r_item.accumulator_mode) begin
                    e_a = r;
                end else begin
                    e_wa[0] = r_item.address; e_wd[0] = r; e_nw = 2'd1;
                end
            end
            K_AND: e_a = r_a & m;
            K_BIT: begin
                e_p[FLAG_N] = m[7];
                e_p[FLAG_V] = m[6];
                e_p[FLAG_Z] = ((r_a & m) == 8'd0);
            end
            K_EOR: e_a = r_a ^ m;
            K_ORA: e_a = r_a | m;
            K_ADC, K_SBC: begin
                mm  = (r_item.kind == K_ADC) ? m : ~m;
                sum = {1'b0, r_a} + {1'b0, mm} + {8'd0, r_p[FLAG_C]};
                e_p[FLAG_C] = sum[8];
                e_p[FLAG_V] = ~(r_a[7] ^ mm[7]) & (r_a[7] ^ sum[7]);
                e_a = sum[7:0];
            end
            K_CMP, K_CPX, K_CPY: begin
                case (t_kind'(r_item.kind))
                    K_CMP:   v = r_a;
                    K_CPX:   v = r_x;
                    default: v = r_y;
                endcase
                e_p[FLAG_C] = (m <= v);
                r = v - m;
            end
            K_DEC: begin r = m - 8'd1; e_wa[0] = r_item.address; e_wd[0] = r; e_nw = 2'd1; end
            K_INC: begin r = m + 8'd1; e_wa[0] = r_item.address; e_wd[0] = r; e_nw = 2'd1; end
            K_DEX: e_x = r_x - 8'd1;
            K_DEY: e_y = r_y - 8'd1;
            K_INX: e_x = r_x + 8'd1;
            K_INY: e_y = r_y + 8'd1;
            K_BRK, K_JSR: begin
                e_wa[0] = {STACK_PAGE, r_sp};
                e_wd[0] = ret[15:8];
                e_wa[1] = {STACK_PAGE, r_sp - 8'd1};
                e_wd[1] = ret[7:0];
                if (r_item.kind == K_BRK) begin
                    e_wa[2] = {STACK_PAGE, r_sp - 8'd2};
                    e_wd[2] = r_p | 8'h30;
                    e_nw    = 2'd3;
                    e_sp    = r_sp - 8'd3;
                    e_p[FLAG_I] = 1'b1;
                end else begin
                    e_nw = 2'd2;
                    e_sp = r_sp - 8'd2;
                end
                nxt = r_item.address;
            end
            K_JMP: nxt = r_item.address;
            K_RTI: begin
                e_p  = (r_b[0] & 8'hEF) | 8'h20;
                nxt  = {r_b[2], r_b[1]};
                e_sp = r_sp + 8'd3;
            end
            K_RTS: begin
                nxt  = {r_b[1], r_b[0]} + 16'd1;
                e_sp = r_sp + 8'd2;
            end
            K_BCC: taken = !r_p[FLAG_C];
            K_BCS: taken = r_p[FLAG_C];
            K_BEQ: taken = r_p[FLAG_Z];
            K_BMI: taken = r_p[FLAG_N];
            K_BNE: taken = !r_p[FLAG_Z];
            K_BPL: taken = !r_p[FLAG_N];
            K_BVC: taken = !r_p[FLAG_V];
            K_BVS: taken = r_p[FLAG_V];
            K_CLC: e_p[FLAG_C] = 1'b0;
            K_CLD: e_p[FLAG_D] = 1'b0;
            K_CLI: e_p[FLAG_I] = 1'b0;
            K_CLV: e_p[FLAG_V] = 1'b0;
            K_SEC: e_p[FLAG_C] = 1'b1;
            K_SED: e_p[FLAG_D] = 1'b1;
            K_SEI: e_p[FLAG_I] = 1'b1;
            default: ;
        endcase

        // N and Z follow the value each class produces.
        case (t_kind'(r_item.kind))
            K_LDA, K_TAX, K_TXA, K_TYA, K_PLA, K_AND, K_EOR, K_ORA, K_ADC, K_SBC: begin
                e_p[FLAG_N] = e_a[7]; e_p[FLAG_Z] = (e_a == 8'd0);
            end
            K_LDX, K_TSX, K_DEX, K_INX: begin
                e_p[FLAG_N] = e_x[7]; e_p[FLAG_Z] = (e_x == 8'd0);
            end
            K_LDY, K_TAY, K_DEY, K_INY: begin
                e_p[FLAG_N] = e_y[7]; e_p[FLAG_Z] = (e_y == 8'd0);
            end
            K_ASL, K_LSR, K_ROL, K_ROR, K_CMP, K_CPX, K_CPY, K_DEC, K_INC: begin
                e_p[FLAG_N] = r[7]; e_p[FLAG_Z] = (r == 8'd0);
            end
            default: ;
        endcase
        e_pc = taken ? r_item.address : nxt;
    end

    // Sequencer: take a word, pull stack bytes, execute, emit results.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_q_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                n_cnt   = 2'd0;
                if (i_q_valid) begin
                    n_state = (i_q_item.pulls != 2'd0) ? S_READ : S_EXEC;
                end
            end
            S_READ: n_state = S_CAP;
            S_CAP: begin
                n_cnt   = r_cnt + 2'd1;
                n_state = (r_cnt + 2'd1 == r_item.pulls) ? S_EXEC : S_READ;
            end
            S_EXEC: begin
                n_cnt   = 2'd0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load && ((r_k + 2'd1 >= r_nw))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_nw    <= '0;
            r_ov    <= 1'b0;
            r_a     <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_sp    <= RESET_SP;
            r_p     <= RESET_P;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_EXEC) begin
                r_a  <= e_a;  r_x <= e_x;  r_y <= e_y;
                r_sp <= e_sp; r_p <= e_p;  r_pc <= e_pc;
                r_nw <= e_nw;
                r_k  <= '0;
            end
            if (load) begin
                r_ov <= 1'b1;
                r_k  <= r_k + 2'd1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers: queued word, pulled bytes, pending writes, result word.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_CAP) begin
            r_b[r_cnt] <= rd_data;
        end
        if (r_state == S_EXEC) begin
            for (int i = 0; i < 3; i++) begin
                r_wa[i] <= e_wa[i];
                r_wd[i] <= e_wd[i];
            end
        end
        if (load) begin
            r_out.mem_write     <= (r_k < r_nw);
            r_out.write_address <= (r_k < r_nw) ? r_wa[r_k] : 16'd0;
            r_out.write_data    <= (r_k < r_nw) ? r_wd[r_k] : 8'd0;
            r_out.next_pc       <= r_pc;
            r_out.reg_a         <= r_a;
            r_out.reg_x         <= r_x;
            r_out.reg_y         <= r_y;
            r_out.stack_pointer <= r_sp;
            r_out.flags         <= r_p;
            r_out.last          <= (r_k + 2'd1 >= r_nw);
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.mem_write     = r_out.mem_write;
    assign o_res.write_address = r_out.write_address;
    assign o_res.write_data    = r_out.write_data;
    assign o_res.next_pc       = r_out.next_pc;
    assign o_res.reg_a         = r_out.reg_a;
    assign o_res.reg_x         = r_out.reg_x;
    assign o_res.reg_y         = r_out.reg_y;
    assign o_res.stack_pointer = r_out.stack_pointer;
    assign o_res.flags         = r_out.flags;
    assign o_res.last          = r_out.last;
endmodule

/* design/cpu6502_execute_unit_core.sv */
// Top level of the 6502 execute unit: front queue and back sequencer.
// Depends on c6502eu_pkg, c6502eu_if, c6502eu_front and c6502eu_back.

// Executes one decoded 6502 instruction per input word and returns one result
// word per memory write or push (up to three), or a single word with no write;
// every result word carries the registers after the instruction and the last
// one is marked. Arithmetic is binary only. The back sequencer takes a word,
// pulls each stack byte through the stack RAM read port in a read state and a
// capture state, executes, and then emits the result words one by one, holding
// each word while the result channel stalls. A two-word queue lets new
// instructions arrive meanwhile.
module cpu6502_execute_unit_core
    import c6502eu_pkg::*;
#(
    parameter int unsigned P_QDEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    c6502eu_in_if.sink    i_in,
    c6502eu_out_if.source o_res
);
    logic  q_valid, q_pop;
    t_item q_item;

    c6502eu_front #(.P_QDEPTH(P_QDEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    c6502eu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );
endmodule

/* design/c6502eu_checker.sv */
// Port-level checker for the 6502 execute unit, bound to the top level.
// Depends on cpu6502_execute_unit_core and its result channel.
module c6502eu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_mem_write,
    input logic [15:0] i_write_address,
    input logic [7:0]  i_write_data,
    input logic        i_last
);
    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_write_address) && $stable(i_last))
        else $error("result word changed while stalled");

    // A word without a write carries zero address and data.
    a_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_mem_write |-> i_write_address == 16'd0 && i_write_data == 8'd0)
        else $error("result without write has non-zero write fields");

    // Only write words can be followed by more words of the same instruction.
    a_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_mem_write)
        else $error("non-final result word carries no write");

    // Nothing is presented right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid straight after reset");
endmodule

bind cpu6502_execute_unit_core c6502eu_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_mem_write     (o_res.mem_write),
    .i_write_address (o_res.write_address),
    .i_write_data    (o_res.write_data),
    .i_last          (o_res.last)
);

/* sim/cpu6502_execute_unit_core_checker.sv */
// Checker for the 6502 execute unit: watches both channels, predicts every
// result word and compares it. Depends on c6502eu_pkg and c6502eu_if.
`timescale 1ns / 100ps

module cpu6502_execute_unit_core_checker
    import c6502eu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    c6502eu_in_if  i_in,
    c6502eu_out_if i_res,
    output int     o_fail_count,
    output int     o_pending
);

    // Predicted architectural state.
    logic [7:0]  reg_a, reg_x, reg_y, reg_sp, reg_p;
    logic [15:0] reg_pc;
    logic [7:0]  page_one [256];

    // Writes produced by the instruction being predicted.
    logic [15:0] wr_addr [3];
    logic [7:0]  wr_data [3];
    int          wr_n;

    t_res expected_q [$];
    int   fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    task automatic set_flag(int unsigned pos, logic on);
        reg_p[pos] = on;
    endtask

    // Sets N and Z from a byte.
    task automatic set_nz(logic [7:0] v);
        reg_p[FLAG_N] = v[7];
        reg_p[FLAG_Z] = (v == 8'h00);
    endtask

    // A write into page one also lands in the stack copy.
    task automatic record_write(logic [15:0] a, logic [7:0] d);
        if (wr_n < 3) begin
            wr_addr[wr_n] = a;
            wr_data[wr_n] = d;
            wr_n++;
        end
        if (a[15:8] == STACK_PAGE) page_one[a[7:0]] = d;
    endtask

    task automatic push_byte(logic [7:0] d);
        record_write({STACK_PAGE, reg_sp}, d);
        reg_sp = reg_sp - 8'd1;
    endtask

    task automatic pull_byte(output logic [7:0] d);
        reg_sp = reg_sp + 8'd1;
        d = page_one[reg_sp];
    endtask

    task automatic add_carry(logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, reg_a} + {1'b0, m} + {8'd0, reg_p[FLAG_C]};
        reg_p[FLAG_C] = sum[8];
        reg_p[FLAG_V] = (~(reg_a[7] ^ m[7])) & (reg_a[7] ^ sum[7]);
        reg_a = sum[7:0];
        set_nz(reg_a);
    endtask

    task automatic compare_reg(logic [7:0] r, logic [7:0] m);
        reg_p[FLAG_C] = (m <= r);
        set_nz(r - m);
    endtask

    // Executes one instruction word and queues its result words.
    task automatic execute_word(logic [5:0] k, logic am, logic [7:0] m,
                                logic [15:0] ad, logic [1:0] len);
        logic [15:0] nxt, ret;
        logic [7:0]  v, r, lo, hi;
        logic        cout, taken, branch;
        t_res        w;
        int          n;
        nxt    = reg_pc + {14'd0, len};
        ret    = reg_pc + 16'd2;
        taken  = 1'b0;
        branch = 1'b0;
        wr_n   = 0;
        case (t_kind'(k))
            K_LDA: begin reg_a = m; set_nz(m); end
            K_LDX: begin reg_x = m; set_nz(m); end
            K_LDY: begin reg_y = m; set_nz(m); end
            K_STA: record_write(ad, reg_a);
            K_STX: record_write(ad, reg_x);
            K_STY: record_write(ad, reg_y);
            K_TAX: begin reg_x = reg_a; set_nz(reg_x); end
            K_TAY: begin reg_y = reg_a; set_nz(reg_y); end
            K_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
            K_TXA: begin reg_a = reg_x; set_nz(reg_a); end
            K_TXS: reg_sp = reg_x;
            K_TYA: begin reg_a = reg_y; set_nz(reg_a); end
            K_PHA: push_byte(reg_a);
            K_PHP: push_byte(reg_p | 8'h30);
            K_PLA: begin pull_byte(v); reg_a = v; set_nz(v); end
            K_PLP: begin pull_byte(v); reg_p = (v & 8'hEF) | 8'h20; end
            K_ASL, K_LSR, K_ROL, K_ROR: begin
                v = am ? reg_a : m;
                case (t_kind'(k))
                    K_ASL:   begin cout = v[7]; r = {v[6:0], 1'b0}; end
                    K_LSR:   begin cout = v[0]; r = {1'b0, v[7:1]}; end
                    K_ROL:   begin cout = v[7]; r = {v[6:0], reg_p[FLAG_C]}; end
                    default: begin cout = v[0]; r = {reg_p[FLAG_C], v[7:1]}; end
                endcase
                reg_p[FLAG_C] = cout;
                set_nz(r);
                if (am) reg_a = r;
                else record_write(ad, r);
            end
            K_AND: begin reg_a = reg_a & m; set_nz(reg_a); end
            K_BIT: begin
                reg_p[FLAG_N] = m[7];
                reg_p[FLAG_V] = m[6];
                reg_p[FLAG_Z] = ((reg_a & m) == 8'h00);
            end
            K_EOR: begin reg_a = reg_a ^ m; set_nz(reg_a); end
            K_ORA: begin reg_a = reg_a | m; set_nz(reg_a); end
            K_ADC: add_carry(m);
            K_CMP: compare_reg(reg_a, m);
            K_CPX: compare_reg(reg_x, m);
            K_CPY: compare_reg(reg_y, m);
            K_SBC: add_carry(~m);
            K_DEC: begin v = m - 8'd1; set_nz(v); record_write(ad, v); end
            K_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            K_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
            K_INC: begin v = m + 8'd1; set_nz(v); record_write(ad, v); end
            K_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
            K_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
            K_BRK: begin
                push_byte(ret[15:8]);
                push_byte(ret[7:0]);
                push_byte(reg_p | 8'h30);
                reg_p[FLAG_I] = 1'b1;
                nxt = ad;
            end
            K_JMP: nxt = ad;
            K_JSR: begin
                push_byte(ret[15:8]);
                push_byte(ret[7:0]);
                nxt = ad;
            end
            K_RTI: begin
                pull_byte(v);
                reg_p = (v & 8'hEF) | 8'h20;
                pull_byte(lo);
                pull_byte(hi);
                nxt = {hi, lo};
            end
            K_RTS: begin
                pull_byte(lo);
                pull_byte(hi);
                nxt = {hi, lo} + 16'd1;
            end
            K_BCC: begin branch = 1'b1; taken = !reg_p[FLAG_C]; end
            K_BCS: begin branch = 1'b1; taken =  reg_p[FLAG_C]; end
            K_BEQ: begin branch = 1'b1; taken =  reg_p[FLAG_Z]; end
            K_BMI: begin branch = 1'b1; taken =  reg_p[FLAG_N]; end
            K_BNE: begin branch = 1'b1; taken = !reg_p[FLAG_Z]; end
            K_BPL: begin branch = 1'b1; taken = !reg_p[FLAG_N]; end
            K_BVC: begin branch = 1'b1; taken = !reg_p[FLAG_V]; end
            K_BVS: begin branch = 1'b1; taken =  reg_p[FLAG_V]; end
            K_CLC: set_flag(FLAG_C, 1'b0);
            K_CLD: set_flag(FLAG_D, 1'b0);
            K_CLI: set_flag(FLAG_I, 1'b0);
            K_CLV: set_flag(FLAG_V, 1'b0);
            K_SEC: set_flag(FLAG_C, 1'b1);
            K_SED: set_flag(FLAG_D, 1'b1);
            K_SEI: set_flag(FLAG_I, 1'b1);
            default: ;
        endcase
        if (branch && taken) nxt = ad;
        reg_pc = nxt;

        // One word per write, or a single word without one.
        n = (wr_n != 0) ? wr_n : 1;
        for (int i = 0; i < n; i++) begin
            w.mem_write     = (i < wr_n);
            w.write_address = (i < wr_n) ? wr_addr[i] : 16'h0000;
            w.write_data    = (i < wr_n) ? wr_data[i] : 8'h00;
            w.next_pc       = reg_pc;
            w.reg_a         = reg_a;
            w.reg_x         = reg_x;
            w.reg_y         = reg_y;
            w.stack_pointer = reg_sp;
            w.flags         = reg_p;
            w.last          = (i == n - 1);
            expected_q.push_back(w);
        end
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fails++;
        end
    endtask

    // Predict on every accepted instruction word, compare every result word.
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            reg_a  = 8'h00;
            reg_x  = 8'h00;
            reg_y  = 8'h00;
            reg_sp = RESET_SP;
            reg_p  = RESET_P;
            reg_pc = 16'h0000;
            expected_q.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                execute_word(i_in.kind, i_in.accumulator_mode, i_in.operand,
                             i_in.address, i_in.instr_length);
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("mem_write", 16'(e.mem_write), 16'(i_res.mem_write));
                    check_field("write_address", e.write_address, i_res.write_address);
                    check_field("write_data", 16'(e.write_data), 16'(i_res.write_data));
                    check_field("next_pc", e.next_pc, i_res.next_pc);
                    check_field("reg_a", 16'(e.reg_a), 16'(i_res.reg_a));
                    check_field("reg_x", 16'(e.reg_x), 16'(i_res.reg_x));
                    check_field("reg_y", 16'(e.reg_y), 16'(i_res.reg_y));
                    check_field("stack_pointer", 16'(e.stack_pointer),
                                16'(i_res.stack_pointer));
                    check_field("flags", 16'(e.flags), 16'(i_res.flags));
                    check_field("last", 16'(e.last), 16'(i_res.last));
                end
            end
        end
    end

    initial fails = 0;

endmodule

/* sim/cpu6502_execute_unit_core_tb.sv */
// Testbench top for the 6502 execute unit: clock, reset, instruction stimulus
// and the verdict. Depends on c6502eu_pkg, c6502eu_if, the core and the checker.
`timescale 1ns / 100ps

module cpu6502_execute_unit_core_tb;
    import c6502eu_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic quiet;
    int   fail_count;
    int   pending;
    int   stall_left;

    c6502eu_in_if  in_ch ();
    c6502eu_out_if res_ch ();

    cpu6502_execute_unit_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    cpu6502_execute_unit_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side stalls in random bursts, except in the quiet tail.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (quiet) begin
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 14);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Presents one instruction word and holds it until it is taken.
    task automatic send_word(logic [5:0] k, logic am, logic [7:0] m,
                             logic [15:0] ad, logic [1:0] len);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.kind             <= k;
        in_ch.accumulator_mode <= am;
        in_ch.operand          <= m;
        in_ch.address          <= ad;
        in_ch.instr_length     <= len;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Any class; pulls only happen inside the stack frames built below.
    task automatic send_any();
        logic [5:0] k;
        k = 6'($urandom_range(0, 63));
        if (k inside {K_PLA, K_PLP, K_RTI, K_RTS}) k = K_NOP;
        send_word(k, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
    endtask

    // Non-stack word with random content, used inside call and interrupt frames.
    task automatic send_plain();
        send_word(6'($urandom_range(K_ASL, K_INY)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  2'($urandom_range(1, 3)));
    endtask

    // Random part: half well-formed stack sequences and compare-then-branch, half any class.
    task automatic send_sequence();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            5: begin
                send_word(K_JSR, 1'b0, 8'h00, 16'($urandom_range(0, 65535)), 2'd3);
                repeat ($urandom_range(0, 3)) send_plain();
                send_word(K_RTS, 1'b0, 8'h00, 16'h0000, 2'd1);
            end
            6: begin
                send_word(K_LDA, 1'b0, 8'($urandom_range(0, 255)), 16'h0000, 2'd2);
                send_word(K_PHA, 1'b0, 8'h00, 16'h0000, 2'd1);
                send_plain();
                send_word(K_PLA, 1'b0, 8'h00, 16'h0000, 2'd1);
            end
            7: begin
                send_word(K_BRK, 1'b0, 8'h00, 16'($urandom_range(0, 65535)), 2'd1);
                repeat ($urandom_range(0, 3)) send_plain();
                send_word(K_RTI, 1'b0, 8'h00, 16'h0000, 2'd1);
            end
            8: begin
                send_word(K_PHP, 1'b0, 8'h00, 16'h0000, 2'd1);
                send_plain();
                send_word(K_PLP, 1'b0, 8'h00, 16'h0000, 2'd1);
            end
            9: begin
                send_word(6'($urandom_range(K_CMP, K_CPY)), 1'b0,
                          8'($urandom_range(0, 255)), 16'h0000, 2'd2);
                send_word(6'($urandom_range(K_BCC, K_BVS)), 1'b0, 8'h00,
                          16'($urandom_range(0, 65535)), 2'd2);
            end
            default: send_any();
        endcase
    endtask

    initial begin
        quiet                  = 1'b0;
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.kind             = 6'd0;
        in_ch.accumulator_mode = 1'b0;
        in_ch.operand          = 8'h00;
        in_ch.address          = 16'h0000;
        in_ch.instr_length     = 2'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, overflow, wrap and the odd cases.
        send_word(K_LDA, 1'b0, 8'h00, 16'h0000, 2'd2);
        send_word(K_LDX, 1'b0, 8'hFF, 16'hFFFF, 2'd2);
        send_word(K_TXS, 1'b1, 8'hFF, 16'h0000, 2'd1);
        send_word(K_LDA, 1'b0, 8'h7F, 16'h0000, 2'd2);
        send_word(K_ADC, 1'b0, 8'h01, 16'h0000, 2'd2);
        send_word(K_SBC, 1'b0, 8'hFF, 16'h0000, 2'd2);
        send_word(K_BIT, 1'b0, 8'hC0, 16'h0000, 2'd3);
        send_word(K_ROL, 1'b1, 8'h00, 16'h0000, 2'd1);
        send_word(K_ROR, 1'b0, 8'h01, 16'h01FF, 2'd3);
        send_word(K_INC, 1'b0, 8'hFF, 16'hFFFF, 2'd3);
        send_word(K_DEC, 1'b0, 8'h00, 16'h0000, 2'd3);
        send_word(K_LDX, 1'b0, 8'h00, 16'h0000, 2'd2);
        send_word(K_TXS, 1'b0, 8'h00, 16'h0000, 2'd1);
        send_word(K_PHA, 1'b0, 8'h00, 16'h0000, 2'd1);
        send_word(K_PLA, 1'b0, 8'h00, 16'h0000, 2'd1);
        send_word(K_JSR, 1'b0, 8'h00, 16'hFFFF, 2'd3);
        send_word(K_RTS, 1'b0, 8'h00, 16'h0000, 2'd1);
        send_word(K_BRK, 1'b0, 8'h00, 16'hFFFE, 2'd1);
        send_word(K_RTI, 1'b0, 8'h00, 16'h0000, 2'd1);
        send_word(K_SED, 1'b0, 8'h00, 16'h0000, 2'd0);
        send_word(K_CLI, 1'b0, 8'h00, 16'h0000, 2'd1);
        send_word(6'd63, 1'b1, 8'hFF, 16'hFFFF, 2'd3);
        send_word(K_BNE, 1'b0, 8'h00, 16'h8000, 2'd2);
        send_word(K_JMP, 1'b0, 8'h00, 16'hFFFF, 2'd3);
        send_word(K_NOP, 1'b0, 8'h00, 16'h0000, 2'd1);

        // Random part; the last stretch runs without idling on either side.
        for (int i = 0; i < 70; i++) send_sequence();
        quiet = 1'b1;
        for (int i = 0; i < 20; i++) send_sequence();
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
